>>> sv/wfac_pkg.sv
package wfac_pkg;

  localparam int unsigned OFFSET_BITS   = 20;
  localparam int unsigned SIZE_BITS     = 21;
  localparam int unsigned FREE_SLOTS_DEF = 16;
  localparam int unsigned USED_SLOTS_DEF = 32;

  localparam logic [SIZE_BITS-1:0] POOL_RESET = 21'd65536;
  localparam logic [SIZE_BITS-1:0] POOL_CAP   = SIZE_BITS'(1 << OFFSET_BITS);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_BADADDR = 3'd2,
    ST_FULL    = 3'd3,
    ST_ZERO    = 3'd4
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct packed {
    logic                   action;
    logic [SIZE_BITS-1:0]   req_size;
    logic [OFFSET_BITS-1:0] block_offset;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [OFFSET_BITS-1:0] granted_offset;
    logic [SIZE_BITS-1:0]   largest_free;
    logic [SIZE_BITS-1:0]   total_free;
  } out_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [SIZE_BITS-1:0]   len;
  } seg_t;

  typedef enum logic [2:0] {
    TBL_NOP,
    TBL_INIT,
    TBL_WR,
    TBL_ERASE,
    TBL_INSERT
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e op;
    seg_t    data;
  } tbl_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_SLOT,
    S_A_UPD,
    S_F_SCAN_U,
    S_F_SCAN_S,
    S_F_MERGE,
    S_PL_UP,
    S_PL_DN,
    S_DONE
  } state_e;

endpackage

>>> sv/worst_fit_allocator_coalescing.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | in_data_i (action, req_size, block_offset)
// out     | output    | out_valid_o/out_stall_i | out_data_o (status, offsets, totals)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (pool_bytes)
//
// one transaction at a time; an allocate does a used slot search, then one swap per
// cycle while re-sorting the segment
// a free scans the used table, then the free table, then updates (used table read once per
// cycle from its ram, free table compared once per cycle on one shared port)
// reset leaves one free segment of 65536 bytes; no clearing pass is needed
// the next input is taken while a result waits on a stalled output
module worst_fit_allocator_coalescing #(
  parameter int unsigned FREE_SLOTS = wfac_pkg::FREE_SLOTS_DEF,
  parameter int unsigned USED_SLOTS = wfac_pkg::USED_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wfac_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wfac_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wfac_pkg::SIZE_BITS-1:0] cfg_data_i
);
  import wfac_pkg::*;

  localparam int unsigned FI = $clog2(FREE_SLOTS);
  localparam int unsigned FC = $clog2(FREE_SLOTS + 1);
  localparam int unsigned UI = $clog2(USED_SLOTS);
  localparam logic [UI-1:0] U_LAST = UI'(USED_SLOTS - 1);

  state_e state_q, state_d;

  in_t                  req_q;
  status_e              st_q;
  logic [SIZE_BITS-1:0] ulen_q;
  logic [OFFSET_BITS-1:0] granted_q;
  logic [SIZE_BITS-1:0] total_q, pool_q;
  logic [USED_SLOTS-1:0] used_valid_q;
  logic [UI-1:0]        scan_q, rd_idx_q, slot_q;
  logic                 rd_vld_q;
  logic [FC-1:0]        fi_q, mi_q, left_q, right_q, pos_q;
  logic                 has_l_q, has_r_q, has_p_q;
  logic [OFFSET_BITS-1:0] loff_q;
  logic [SIZE_BITS-1:0] llen_q, rlen_q;
  seg_t                 mov_q;
  out_t                 out_q;
  logic                 out_valid_q;

  tbl_cmd_t       tbl_cmd;
  logic [FI-1:0]  tbl_idx, tbl_rd_idx;
  seg_t           rd_seg, front;
  logic [FC-1:0]  count;
  logic [SIZE_BITS-1:0] cfg_len;

  logic           ram_we;
  seg_t           ram_wdata, ram_rdata;

  logic           cfg_fire, in_fire, out_go;
  logic           match_u, u_last, is_left, is_right, f_last;
  logic           up_go, dn_go, tbl_room, merged;
  logic [SIZE_BITS-1:0] new_len;
  logic [SIZE_BITS:0]   seg_end, blk_end;

  wfac_seg_tbl #(.FREE_SLOTS(FREE_SLOTS)) u_seg_tbl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .idx_i      (tbl_idx),
    .init_len_i (cfg_len),
    .rd_idx_i   (tbl_rd_idx),
    .rd_seg_o   (rd_seg),
    .front_o    (front),
    .count_o    (count)
  );

  wfac_ram #(.WIDTH($bits(seg_t)), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign cfg_len   = cfg_data_i[SIZE_BITS-1] ? POOL_CAP : cfg_data_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_go    = !out_valid_q || !out_stall_i;

  assign match_u   = rd_vld_q && used_valid_q[rd_idx_q] &&
                     (ram_rdata.off == req_q.block_offset);
  assign u_last    = rd_vld_q && (rd_idx_q == U_LAST);
  assign seg_end   = (SIZE_BITS+1)'(rd_seg.off) + (SIZE_BITS+1)'(rd_seg.len);
  assign blk_end   = (SIZE_BITS+1)'(req_q.block_offset) + (SIZE_BITS+1)'(ulen_q);
  assign is_left   = (seg_end == (SIZE_BITS+1)'(req_q.block_offset));
  assign is_right  = ((SIZE_BITS+1)'(rd_seg.off) == blk_end);
  assign f_last    = (fi_q == count - FC'(1));
  assign up_go     = (mi_q != '0) && (mov_q.len > rd_seg.len);
  assign dn_go     = (((FC+1)'(mi_q) + (FC+1)'(1)) < (FC+1)'(count)) &&
                     (mov_q.len < rd_seg.len);
  assign tbl_room  = (count < FC'(FREE_SLOTS));
  assign merged    = has_l_q || has_r_q;
  assign new_len   = front.len - ulen_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = in_data_i.action ? S_F_SCAN_U : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (ulen_q == '0 || count == '0 || ulen_q > front.len) begin
          state_d = S_DONE;
        end else begin
          state_d = S_A_SLOT;
        end
      end
      S_A_SLOT: begin
        if (!used_valid_q[scan_q]) begin
          state_d = S_A_UPD;
        end else if (scan_q == U_LAST) begin
          state_d = S_DONE;
        end
      end
      S_A_UPD: begin
        state_d = (new_len == '0) ? S_DONE : S_PL_UP;
      end
      S_F_SCAN_U: begin
        if (match_u) begin
          state_d = (count == '0) ? S_F_MERGE : S_F_SCAN_S;
        end else if (u_last) begin
          state_d = S_DONE;
        end
      end
      S_F_SCAN_S: begin
        if (f_last) begin
          state_d = S_F_MERGE;
        end
      end
      S_F_MERGE: begin
        state_d = merged ? S_PL_UP : S_DONE;
      end
      S_PL_UP: begin
        if (!up_go) begin
          state_d = S_PL_DN;
        end
      end
      S_PL_DN: begin
        if (!dn_go) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // table and ram control
  always_comb begin
    tbl_cmd    = '{op: TBL_NOP, data: '0};
    tbl_idx    = '0;
    tbl_rd_idx = '0;
    ram_we     = 1'b0;
    ram_wdata  = '{off: front.off, len: ulen_q};
    case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          tbl_cmd.op = TBL_INIT;
        end
      end
      S_A_UPD: begin
        ram_we = 1'b1;
        if (new_len == '0) begin
          tbl_cmd.op = TBL_ERASE;
        end
      end
      S_F_SCAN_S: begin
        tbl_rd_idx = fi_q[FI-1:0];
      end
      S_F_MERGE: begin
        if (has_l_q && has_r_q) begin
          tbl_cmd.op = TBL_ERASE;
          tbl_idx    = right_q[FI-1:0];
        end else if (!merged && tbl_room) begin
          tbl_cmd.op   = TBL_INSERT;
          tbl_cmd.data = '{off: req_q.block_offset, len: ulen_q};
          tbl_idx      = has_p_q ? pos_q[FI-1:0] : count[FI-1:0];
        end
      end
      S_PL_UP: begin
        tbl_rd_idx = FI'(mi_q - FC'(1));
        tbl_idx    = mi_q[FI-1:0];
        if (up_go) begin
          tbl_cmd = '{op: TBL_WR, data: rd_seg};
        end
      end
      S_PL_DN: begin
        tbl_rd_idx = FI'(mi_q + FC'(1));
        tbl_idx    = mi_q[FI-1:0];
        tbl_cmd    = '{op: TBL_WR, data: dn_go ? rd_seg : mov_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pool_q       <= POOL_RESET;
      total_q      <= POOL_RESET;
      used_valid_q <= '0;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_F_SCAN_U);
      if (state_q == S_DONE && out_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        pool_q       <= cfg_len;
        total_q      <= cfg_len;
        used_valid_q <= '0;
      end
      if (state_q == S_A_UPD) begin
        used_valid_q[slot_q] <= 1'b1;
        total_q              <= total_q - ulen_q;
      end
      if (state_q == S_F_MERGE && (merged || tbl_room)) begin
        used_valid_q[slot_q] <= 1'b0;
        total_q              <= total_q + ulen_q;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
    case (state_q)
      S_IDLE: begin
        req_q     <= in_data_i;
        ulen_q    <= in_data_i.req_size;
        st_q      <= ST_OK;
        granted_q <= '0;
        scan_q    <= '0;
        fi_q      <= '0;
        has_l_q   <= 1'b0;
        has_r_q   <= 1'b0;
        has_p_q   <= 1'b0;
      end
      S_A_CHK: begin
        if (ulen_q == '0) begin
          st_q <= ST_ZERO;
        end else if (count == '0 || ulen_q > front.len) begin
          st_q <= ST_OOM;
        end
      end
      S_A_SLOT: begin
        slot_q <= scan_q;
        if (used_valid_q[scan_q]) begin
          if (scan_q == U_LAST) begin
            st_q <= ST_FULL;
          end else begin
            scan_q <= scan_q + UI'(1);
          end
        end
      end
      S_A_UPD: begin
        granted_q <= front.off;
        mov_q     <= '{off: OFFSET_BITS'(front.off + ulen_q), len: new_len};
        mi_q      <= '0;
      end
      S_F_SCAN_U: begin
        if (scan_q != U_LAST) begin
          scan_q <= scan_q + UI'(1);
        end
        if (match_u) begin
          slot_q <= rd_idx_q;
          ulen_q <= ram_rdata.len;
        end else if (u_last) begin
          st_q <= ST_BADADDR;
        end
      end
      S_F_SCAN_S: begin
        fi_q <= fi_q + FC'(1);
        if (is_left) begin
          has_l_q <= 1'b1;
          left_q  <= fi_q;
          loff_q  <= rd_seg.off;
          llen_q  <= rd_seg.len;
        end
        if (is_right) begin
          has_r_q <= 1'b1;
          right_q <= fi_q;
          rlen_q  <= rd_seg.len;
        end
        if (!has_p_q && rd_seg.len <= ulen_q) begin
          has_p_q <= 1'b1;
          pos_q   <= fi_q;
        end
      end
      S_F_MERGE: begin
        if (has_l_q && has_r_q) begin
          mov_q <= '{off: loff_q, len: llen_q + rlen_q + ulen_q};
          mi_q  <= (right_q < left_q) ? left_q - FC'(1) : left_q;
        end else if (has_l_q) begin
          mov_q <= '{off: loff_q, len: llen_q + ulen_q};
          mi_q  <= left_q;
        end else if (has_r_q) begin
          mov_q <= '{off: req_q.block_offset, len: rlen_q + ulen_q};
          mi_q  <= right_q;
        end else if (!tbl_room) begin
          st_q <= ST_FULL;
        end
      end
      S_PL_UP: begin
        if (up_go) begin
          mi_q <= mi_q - FC'(1);
        end
      end
      S_PL_DN: begin
        if (dn_go) begin
          mi_q <= mi_q + FC'(1);
        end
      end
      S_DONE: begin
        if (out_go) begin
          out_q.status         <= st_q;
          out_q.granted_offset <= granted_q;
          out_q.largest_free   <= (count != '0) ? front.len : '0;
          out_q.total_free     <= total_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= FC'(FREE_SLOTS))
    else $error("free segment count beyond table size");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pool_q)
    else $error("free total beyond pool size");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");

endmodule

>>> sv/wfac_ram.sv
module wfac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/wfac_seg_tbl.sv
module wfac_seg_tbl #(
  parameter int unsigned FREE_SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wfac_pkg::tbl_cmd_t                cmd_i,
  input  logic [$clog2(FREE_SLOTS)-1:0]     idx_i,
  input  logic [wfac_pkg::SIZE_BITS-1:0]    init_len_i,
  input  logic [$clog2(FREE_SLOTS)-1:0]     rd_idx_i,
  output wfac_pkg::seg_t                    rd_seg_o,
  output wfac_pkg::seg_t                    front_o,
  output logic [$clog2(FREE_SLOTS+1)-1:0]   count_o
);
  import wfac_pkg::*;

  localparam int unsigned FI = $clog2(FREE_SLOTS);
  localparam int unsigned FC = $clog2(FREE_SLOTS + 1);

  seg_t          seg_q [FREE_SLOTS];
  logic [FC-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < FREE_SLOTS; i++) begin
        seg_q[i] <= '0;
      end
      seg_q[0] <= '{off: '0, len: POOL_RESET};
      count_q  <= FC'(1);
    end else begin
      case (cmd_i.op)
        TBL_INIT: begin
          seg_q[0] <= '{off: '0, len: init_len_i};
          count_q  <= (init_len_i != '0) ? FC'(1) : '0;
        end
        TBL_WR: begin
          seg_q[idx_i] <= cmd_i.data;
        end
        TBL_ERASE: begin
          for (int i = 0; i < FREE_SLOTS - 1; i++) begin
            if (FI'(i) >= idx_i) begin
              seg_q[i] <= seg_q[i+1];
            end
          end
          count_q <= count_q - FC'(1);
        end
        TBL_INSERT: begin
          for (int i = 1; i < FREE_SLOTS; i++) begin
            if (FI'(i) > idx_i) begin
              seg_q[i] <= seg_q[i-1];
            end
          end
          seg_q[idx_i] <= cmd_i.data;
          count_q      <= count_q + FC'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_seg_o = seg_q[rd_idx_i];
  assign front_o  = seg_q[0];
  assign count_o  = count_q;

endmodule
